FILE: src/fsqrt_pkg.sv
// Shared types and constants for the single-precision square root block.
package fsqrt_pkg;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] PINF_BITS = 32'h7F80_0000;
	localparam int ROOT_STEPS = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_OUT
	} fsqrt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} fsqrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic special;
		logic last_step;
	} fsqrt_stat_t;

endpackage

FILE: src/float_sqrt_newton_top.sv
// Top level of the single-precision square root block.
//  channel | direction | handshake                 | payload
//  in      | into      | in_valid / in_ready       | operand_bits
//  out     | out of    | out_valid / out_ready     | root_bits, invalid_flag
// A normal operand is loaded, then the one-digit-a-cycle root unit forms the root,
// and then the result is shown.
// Zero, infinity, NaN and negative operands skip the root steps.
// A new request is accepted in the cycle the previous result is taken.
// Reset returns the controller to idle; a held result stalls the block.
module float_sqrt_newton_top
	import fsqrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root_bits,
	output logic        invalid_flag
);

	fsqrt_cmd_t  cmd;
	fsqrt_stat_t stat;

	fsqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	fsqrt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operand_bits (operand_bits),
		.root_bits    (root_bits),
		.invalid_flag (invalid_flag)
	);

endmodule

FILE: src/fsqrt_ctrl.sv
// Controller state machine for the square root block.
module fsqrt_ctrl
	import fsqrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output fsqrt_cmd_t  cmd,
	input  fsqrt_stat_t stat
);

	fsqrt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ITER;
				end
			end
			ST_ITER: begin
				if (stat.special) begin
					state_d = ST_OUT;
				end else begin
					cmd.step = 1'b1;
					if (stat.last_step) begin
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					// A new request may be taken as the result leaves.
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_ITER;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: src/fsqrt_dp.sv
// Datapath: operand decode, bit-serial integer root and result packing.
module fsqrt_dp
	import fsqrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fsqrt_cmd_t  cmd,
	output fsqrt_stat_t stat,
	input  logic [31:0] operand_bits,
	output logic [31:0] root_bits,
	output logic        invalid_flag
);

	localparam int CW = $clog2(ROOT_STEPS + 1);

	logic [49:0] rem_q;      // partial remainder
	logic [23:0] root_q;     // partial root
	logic [47:0] rad_q;      // radicand, shifted out two bits a step
	logic [CW-1:0] cnt_q;
	logic        special_q;
	logic [31:0] res_q;
	logic        inv_q;
	logic signed [9:0] q_q;  // result exponent

	// Decode of the incoming operand.
	logic        sign;
	logic [7:0]  expf;
	logic [22:0] frac;
	logic [4:0]  lz;
	logic [23:0] mnorm;
	logic signed [9:0] e;
	logic [25:0] m2;
	logic signed [9:0] e2;
	logic        sp;
	logic [31:0] sp_res;
	logic        sp_inv;

	always_comb begin
		sign  = operand_bits[31];
		expf  = operand_bits[30:23];
		frac  = operand_bits[22:0];
		lz    = '0;
		for (int i = 0; i < 23; i++) begin
			if (frac[i]) lz = 5'(22 - i);
		end
		if (expf == 8'd0) begin
			mnorm = {1'b0, frac} << (lz + 5'd1);
			e     = -10'sd149 - 10'(lz) - 10'sd1;
		end else begin
			mnorm = {1'b1, frac};
			e     = 10'(expf) - 10'sd150;
		end
		if (e[0]) begin
			m2 = {1'b0, mnorm, 1'b0};
			e2 = e - 10'sd1;
		end else begin
			m2 = {mnorm, 2'b00};
			e2 = e - 10'sd2;
		end
		sp     = 1'b1;
		sp_inv = 1'b0;
		sp_res = PINF_BITS;
		if (expf == 8'hFF && frac != '0) begin
			sp_inv = ~frac[22];
			sp_res = operand_bits | 32'h0040_0000;
		end else if (expf == 8'd0 && frac == '0) begin
			sp_res = '0;
		end else if (sign) begin
			sp_res = QNAN_BITS;
			sp_inv = 1'b1;
		end else if (expf == 8'hFF) begin
			sp_res = PINF_BITS;
		end else begin
			sp = 1'b0;
		end
	end

	// One restoring root digit a step.
	logic [49:0] trial;
	logic [49:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[47:0], rad_q[47:46]};
		trial  = {24'd0, root_q, 2'b01};
	end

	logic [23:0] rnd;
	always_comb begin
		// A remainder above the root means the true root is above r + 0.5.
		rnd = root_q + 24'(rem_q > {26'd0, root_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			special_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q     <= '0;
			special_q <= sp;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= {m2, 22'd0};
			q_q    <= (e2 - 10'sd22) >>> 1;
			res_q  <= sp_res;
			inv_q  <= sp_inv;
		end else if (cmd.step) begin
			rad_q <= {rad_q[45:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[22:0], 1'b0};
			end
		end
	end

	assign stat.special   = special_q;
	assign stat.last_step = (cnt_q == CW'(ROOT_STEPS - 1));

	logic [31:0] packed_res;
	always_comb begin
		packed_res = ({22'd0, 10'(q_q + 10'sd150)} << 23) + {8'd0, rnd - 24'h80_0000};
	end

	assign root_bits    = special_q ? res_q : packed_res;
	assign invalid_flag = special_q ? inv_q : 1'b0;

endmodule

FILE: src/fsqrt_chk.sv
// Port-level checker for the square root block, bound to the top level.
module fsqrt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] root_bits,
	input logic        invalid_flag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_bits) && $stable(invalid_flag))
		else $error("result changed while stalled");

	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("request taken while result pending");

	a_accept_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown in the cycle after a request");

	a_inv_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_flag |-> root_bits[30:22] == 9'h1FF)
		else $error("invalid result is not a quiet NaN");

endmodule

bind float_sqrt_newton_top fsqrt_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.root_bits    (root_bits),
	.invalid_flag (invalid_flag)
);

FILE: dv/tb_float_sqrt_newton_top.sv
// Testbench for the single-precision square root block: predicts each root and checks it.
`timescale 1ns / 1ps

module tb_float_sqrt_newton_top;
	import fsqrt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [31:0] root;
		logic        invalid;
	} root_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] operand_bits;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] root_bits;
	logic        invalid_flag;

	root_result_t expected_roots[$];
	int  error_count;
	int  idle_cycles;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;

	float_sqrt_newton_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operand_bits(operand_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.root_bits   (root_bits),
		.invalid_flag(invalid_flag)
	);

	always #5 clk = ~clk;

	// Floor square root of a value below 2^48, digit by digit, with remainder.
	function automatic logic [63:0] floor_root48(input logic [63:0] radicand,
		output logic [63:0] remainder);
		logic [63:0] acc;
		logic [63:0] digit;
		acc = 0;
		digit = 64'd1 << 46;
		while (digit != 0) begin
			if (radicand >= acc + digit) begin
				radicand = radicand - (acc + digit);
				acc = (acc >> 1) + digit;
			end else begin
				acc = acc >> 1;
			end
			digit = digit >> 2;
		end
		remainder = radicand;
		return acc;
	endfunction

	function automatic root_result_t predict_root(input logic [31:0] a);
		root_result_t rr;
		logic [7:0]  expf;
		logic [22:0] frac;
		logic [63:0] sig;
		logic [63:0] r;
		logic [63:0] rem;
		int          e;
		int          q;
		expf = a[30:23];
		frac = a[22:0];
		rr.invalid = 1'b0;
		if (expf == 8'hFF && frac != 0) begin
			rr.invalid = ~frac[22];
			rr.root = a | 32'h0040_0000;
		end else if (expf == 0 && frac == 0) begin
			rr.root = 32'h0;
		end else if (a[31]) begin
			rr.root = QNAN_BITS;
			rr.invalid = 1'b1;
		end else if (expf == 8'hFF) begin
			rr.root = PINF_BITS;
		end else begin
			if (expf == 0) begin
				sig = {41'd0, frac};
				e = -149;
				while (sig[23] == 1'b0) begin
					sig = sig << 1;
					e = e - 1;
				end
			end else begin
				sig = {40'd0, 1'b1, frac};
				e = int'(expf) - 150;
			end
			// Even exponent keeps the significand in [2^24, 2^26).
			if (e % 2 != 0) begin
				sig = sig << 1;
				e = e - 1;
			end else begin
				sig = sig << 2;
				e = e - 2;
			end
			r = floor_root48(sig << 22, rem);
			if (rem > r)
				r = r + 1;
			q = (e - 22) / 2;
			rr.root = (32'(q + 150) << 23) + 32'(r - 64'h80_0000);
		end
		return rr;
	endfunction

	// Valid stays high between back-to-back requests; it drops only while idling.
	task automatic send_operand(input logic [31:0] a);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operand_bits <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_roots.push_back(predict_root(a));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] a;
		a = $urandom;
		case ($urandom_range(9))
			0: a[30:23] = 8'h00;
			1: a[30:23] = 8'hFF;
			2: a[30:23] = $urandom_range(1) ? 8'hFE : 8'h01;
			3, 4: a[31] = 1'b1;
			default: a[31] = 1'b0;
		endcase
		return a;
	endfunction

	task automatic test_special_cases();
		logic [31:0] ops[$];
		ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFC1_2345, 32'h7F80_0001, 32'hFFBF_FFFF,
			32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h8000_0001,
			32'h3F80_0000, 32'h4000_0000, 32'h4080_0000, 32'h7F7F_FFFF,
			32'h0080_0000, 32'h3F7F_FFFF, 32'hBF80_0000, 32'h5555_5555,
			32'h2AAA_AAAA};
		foreach (ops[i])
			send_operand(ops[i]);
		wait_drained();
	endtask

	task automatic test_random_phase(input int count, input int send_pct,
		input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_operand(random_operand());
		wait_drained();
	endtask

	// The receiver holds off while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b1;
		repeat (20)
			send_operand(random_operand());
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	initial begin : hold_off_timer
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				held++;
				if (held >= 300) begin
					hold_off = 1'b0;
					held = 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		root_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_roots.size() == 0) begin
				$error("unexpected result root_bits=%h", root_bits);
				error_count++;
			end else begin
				exp_r = expected_roots.pop_front();
				if (root_bits !== exp_r.root) begin
					$error("root_bits expected %h actual %h", exp_r.root, root_bits);
					error_count++;
				end
				if (invalid_flag !== exp_r.invalid) begin
					$error("invalid_flag expected %b actual %b", exp_r.invalid,
						invalid_flag);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand_bits = '0;
		out_ready = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_special_cases();
		test_random_phase(200, 0, 0);
		test_backpressure();
		test_random_phase(220, 75, 0);
		test_random_phase(220, 0, 75);
		test_random_phase(220, 12, 12);
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
src/fsqrt_pkg.sv
src/fsqrt_ctrl.sv
src/fsqrt_dp.sv
src/float_sqrt_newton_top.sv
src/fsqrt_chk.sv
dv/tb_float_sqrt_newton_top.sv
